### hdl/mfp_pkg.sv
// Shared types and constants for the MIDI file event parser.
`timescale 1ns / 1ps
package mfp_pkg;

  typedef enum logic [4:0] {
    PH_HID, PH_HLEN, PH_HFMT, PH_HNTRK, PH_HDIV, PH_TID, PH_TLEN, PH_DELTA,
    PH_STATUS, PH_DATA1, PH_DATA2, PH_MTYPE, PH_SKIPLEN, PH_SKIP, PH_ENDPEND,
    PH_DONE
  } phase_t;

  localparam logic [3:0] K_HEADER  = 4'd0;
  localparam logic [3:0] K_NOTEOFF = 4'd1;
  localparam logic [3:0] K_NOTEON  = 4'd2;
  localparam logic [3:0] K_END     = 4'd8;
  localparam logic [3:0] K_ERROR   = 4'd9;

  localparam logic [2:0] E_NONE    = 3'd0;
  localparam logic [2:0] E_MTHD    = 3'd1;
  localparam logic [2:0] E_HLEN    = 3'd2;
  localparam logic [2:0] E_MTRK    = 3'd3;
  localparam logic [2:0] E_STATUS  = 3'd4;

  localparam logic [7:0] ST_SYSEX  = 8'hF0;
  localparam logic [7:0] ST_ESCAPE = 8'hF7;
  localparam logic [7:0] ST_META   = 8'hFF;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  chan;
    logic [6:0]  d1;
    logic [6:0]  d2;
    logic [31:0] tick;
    logic [15:0] trk;
    logic [15:0] fmt;
    logic [15:0] ntrk;
    logic [15:0] div;
    logic [2:0]  code;
  } result_t;

  // Chunk id characters, indexed by byte position
  function automatic logic [7:0] head_id(input logic [1:0] i);
    case (i)
      2'd0:    head_id = 8'h4D;
      2'd1:    head_id = 8'h54;
      2'd2:    head_id = 8'h68;
      default: head_id = 8'h64;
    endcase
  endfunction

  function automatic logic [7:0] trk_id(input logic [1:0] i);
    case (i)
      2'd0:    trk_id = 8'h4D;
      2'd1:    trk_id = 8'h54;
      2'd2:    trk_id = 8'h72;
      default: trk_id = 8'h6B;
    endcase
  endfunction

  function automatic logic one_param(input logic [7:0] st);
    one_param = (st[7:5] == 3'b110);
  endfunction

endpackage

### hdl/mfp_parse.sv
// Parser state and per-byte next-state logic.
`timescale 1ns / 1ps
module mfp_parse import mfp_pkg::*; #(
  parameter int TICK_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] file_byte,
  input  logic       file_start,
  output logic       res_valid,
  output result_t    res
);

  localparam int SW = TICK_WIDTH + 33;

  phase_t                  phase, phase_next;
  logic [2:0]              fbc, fbc_next;
  logic [31:0]             shift, shift_next;
  logic [15:0]             hfmt, hfmt_next, hntrk, hntrk_next, hdiv, hdiv_next;
  logic [15:0]             track, track_next;
  logic [31:0]             chunk, chunk_next;
  logic [TICK_WIDTH-1:0]   ttime, ttime_next;
  logic [7:0]              rstat, rstat_next;
  logic [6:0]              held, held_next;
  logic [31:0]             skip, skip_next;

  function automatic logic [31:0] tick32(input logic [TICK_WIDTH-1:0] t);
    logic [TICK_WIDTH+31:0] ext;
    ext = {32'b0, t};
    tick32 = ext[31:0];
  endfunction

  logic [SW-1:0] tsum;
  logic          failed, emitted;
  logic [2:0]    fcode;
  logic [7:0]    st;
  logic [6:0]    dd2;

  // Work one byte from the state as it stands, or from reset on a new file
  always_comb begin
    phase_next = file_start ? PH_HID : phase;
    fbc_next   = file_start ? '0 : fbc;
    shift_next = file_start ? '0 : shift;
    hfmt_next  = file_start ? '0 : hfmt;
    hntrk_next = file_start ? '0 : hntrk;
    hdiv_next  = file_start ? '0 : hdiv;
    track_next = file_start ? '0 : track;
    chunk_next = file_start ? '0 : chunk;
    ttime_next = file_start ? '0 : ttime;
    rstat_next = file_start ? '0 : rstat;
    held_next  = file_start ? '0 : held;
    skip_next  = file_start ? '0 : skip;
    res        = '0;
    res_valid  = 1'b0;
    failed     = 1'b0;
    emitted    = 1'b0;
    fcode      = E_NONE;
    tsum       = '0;
    st         = '0;
    dd2        = '0;

    unique case (phase_next)
      PH_DONE: ;
      PH_HID, PH_TID: begin
        if (file_byte != ((phase_next == PH_HID) ? head_id(fbc_next[1:0])
                                                 : trk_id(fbc_next[1:0]))) begin
          failed = 1'b1;
          fcode  = (phase_next == PH_HID) ? E_MTHD : E_MTRK;
        end else begin
          fbc_next = fbc_next + 3'd1;
          if (fbc_next == 3'd4) begin
            fbc_next   = '0;
            shift_next = '0;
            phase_next = (phase_next == PH_HID) ? PH_HLEN : PH_TLEN;
          end
        end
      end
      PH_HLEN, PH_TLEN: begin
        shift_next = {shift_next[23:0], file_byte};
        fbc_next   = fbc_next + 3'd1;
        if (fbc_next == 3'd4) begin
          fbc_next = '0;
          if (phase_next == PH_HLEN) begin
            if (shift_next != 32'd6) begin
              failed = 1'b1;
              fcode  = E_HLEN;
            end else begin
              shift_next = '0;
              phase_next = PH_HFMT;
            end
          end else begin
            chunk_next = shift_next;
            shift_next = '0;
            ttime_next = '0;
            rstat_next = '0;
            phase_next = PH_DELTA;
            if (chunk_next == '0) begin
              track_next = track_next + 16'd1;
              if (track_next == hntrk_next) begin
                phase_next = PH_DONE;
                res_valid  = 1'b1;
                res.kind   = K_END;
                res.tick   = tick32(ttime_next);
                res.trk    = track_next;
              end else begin
                phase_next = PH_TID;
              end
            end
          end
        end
      end
      PH_HFMT, PH_HNTRK, PH_HDIV: begin
        shift_next = {shift_next[23:0], file_byte};
        fbc_next   = fbc_next + 3'd1;
        if (fbc_next == 3'd2) begin
          fbc_next = '0;
          if (phase_next == PH_HFMT) begin
            hfmt_next  = shift_next[15:0];
            phase_next = PH_HNTRK;
          end else if (phase_next == PH_HNTRK) begin
            hntrk_next = shift_next[15:0];
            phase_next = PH_HDIV;
          end else begin
            hdiv_next  = shift_next[15:0];
            phase_next = (hntrk_next == '0) ? PH_ENDPEND : PH_TID;
            res_valid  = 1'b1;
            res.kind   = K_HEADER;
          end
          shift_next = '0;
        end
      end
      PH_ENDPEND: begin
        phase_next = PH_DONE;
        res_valid  = 1'b1;
        res.kind   = K_END;
        res.tick   = tick32(ttime_next);
        res.trk    = track_next;
      end
      default: begin
        // Track body byte
        case (phase_next)
          PH_DELTA, PH_SKIPLEN: begin
            shift_next = {shift_next[24:0], file_byte[6:0]};
            fbc_next   = fbc_next + 3'd1;
            if (file_byte[7]) begin
              if (fbc_next >= 3'd4) begin
                failed = 1'b1;
                fcode  = E_STATUS;
              end
            end else if (phase_next == PH_DELTA) begin
              tsum = {33'b0, ttime_next} + {{(TICK_WIDTH + 1){1'b0}}, shift_next};
              ttime_next = (|tsum[SW-1:TICK_WIDTH]) ? '1 : tsum[TICK_WIDTH-1:0];
              fbc_next   = '0;
              shift_next = '0;
              phase_next = PH_STATUS;
            end else begin
              skip_next  = shift_next;
              fbc_next   = '0;
              shift_next = '0;
              phase_next = (skip_next == '0) ? PH_DELTA : PH_SKIP;
            end
          end
          PH_STATUS, PH_DATA1, PH_DATA2: begin
            if (phase_next == PH_STATUS && file_byte[7]) begin
              if (file_byte < ST_SYSEX) begin
                rstat_next = file_byte;
                phase_next = PH_DATA1;
              end else if (file_byte == ST_SYSEX || file_byte == ST_ESCAPE) begin
                rstat_next = '0;
                phase_next = PH_SKIPLEN;
              end else if (file_byte == ST_META) begin
                rstat_next = '0;
                phase_next = PH_MTYPE;
              end else begin
                failed = 1'b1;
                fcode  = E_STATUS;
              end
            end else if (file_byte[7] || (phase_next == PH_STATUS && rstat_next == '0)) begin
              failed = 1'b1;
              fcode  = E_STATUS;
            end else if (phase_next == PH_DATA2 || one_param(rstat_next)) begin
              // Complete channel event
              st       = rstat_next;
              res.d1   = (phase_next == PH_DATA2) ? held_next : file_byte[6:0];
              dd2      = (phase_next == PH_DATA2) ? file_byte[6:0] : 7'd0;
              res.kind = {1'b0, st[6:4]} + 4'd1;
              if (res.kind == K_NOTEON && dd2 == '0) begin
                res.kind = K_NOTEOFF;
                dd2      = 7'h40;
              end
              res.d2     = dd2;
              res.chan   = st[3:0];
              res.tick   = tick32(ttime_next);
              res.trk    = track_next;
              res_valid  = 1'b1;
              emitted    = 1'b1;
              phase_next = PH_DELTA;
              fbc_next   = '0;
              shift_next = '0;
            end else begin
              held_next  = file_byte[6:0];
              phase_next = PH_DATA2;
            end
          end
          PH_MTYPE: begin
            fbc_next   = '0;
            shift_next = '0;
            phase_next = PH_SKIPLEN;
          end
          default: begin
            skip_next = skip_next - 32'd1;
            if (skip_next == '0) phase_next = PH_DELTA;
          end
        endcase

        // Count down the chunk and close the track at its end
        if (!failed) begin
          chunk_next = chunk_next - 32'd1;
          if (chunk_next == '0) begin
            if (phase_next != PH_DELTA || fbc_next != '0) begin
              failed = 1'b1;
              fcode  = E_STATUS;
            end else begin
              track_next = track_next + 16'd1;
              fbc_next   = '0;
              shift_next = '0;
              if (track_next == hntrk_next) begin
                if (emitted) begin
                  phase_next = PH_ENDPEND;
                end else begin
                  phase_next = PH_DONE;
                  res_valid  = 1'b1;
                  res.kind   = K_END;
                  res.tick   = tick32(ttime_next);
                  res.trk    = track_next;
                end
              end else begin
                phase_next = PH_TID;
              end
            end
          end
        end
      end
    endcase

    // Error result replaces anything else from this byte
    if (failed) begin
      phase_next = PH_DONE;
      res        = '0;
      res_valid  = 1'b1;
      res.kind   = K_ERROR;
      res.code   = fcode;
      res.tick   = tick32(ttime_next);
      res.trk    = track_next;
    end
    res.fmt  = hfmt_next;
    res.ntrk = hntrk_next;
    res.div  = hdiv_next;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HID;
      fbc   <= '0;
      rstat <= '0;
    end else if (accept) begin
      phase <= phase_next;
      fbc   <= fbc_next;
      rstat <= rstat_next;
    end
  end

  // Datapath state
  always_ff @(posedge clk) begin
    if (rst) begin
      shift <= '0;
      hfmt  <= '0;
      hntrk <= '0;
      hdiv  <= '0;
      track <= '0;
      chunk <= '0;
      ttime <= '0;
      held  <= '0;
      skip  <= '0;
    end else if (accept) begin
      shift <= shift_next;
      hfmt  <= hfmt_next;
      hntrk <= hntrk_next;
      hdiv  <= hdiv_next;
      track <= track_next;
      chunk <= chunk_next;
      ttime <= ttime_next;
      held  <= held_next;
      skip  <= skip_next;
    end
  end

endmodule

### hdl/mfp_outbuf.sv
// Result register with a skid stage behind it.
`timescale 1ns / 1ps
module mfp_outbuf import mfp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t din,
  output logic    full,
  output logic    dout_valid,
  input  logic    dout_stall,
  output result_t dout
);

  logic    sk_valid;
  result_t sk;
  logic    taken;

  assign taken = dout_valid && !dout_stall;
  assign full  = sk_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      dout_valid <= 1'b0;
      sk_valid   <= 1'b0;
    end else begin
      if (push) begin
        dout_valid <= 1'b1;
        sk_valid   <= dout_valid && (!taken || sk_valid);
      end else if (taken) begin
        dout_valid <= sk_valid;
        sk_valid   <= 1'b0;
      end
    end
  end

  // Payload moves
  always_ff @(posedge clk) begin
    if (!dout_valid || (taken && !sk_valid)) begin
      if (push) dout <= din;
    end else if (taken) begin
      dout <= sk;
    end
    if (push && dout_valid && (!taken || sk_valid)) sk <= din;
  end

endmodule

### hdl/midi_file_event_parser.sv
// Top level of the MIDI file event parser.
// Each result is registered in the output buffer before it reaches the outputs.
// Throughput: one byte per cycle when not stalled; parsing is one pass of logic.
// A two-entry result buffer lets bytes flow while one result waits downstream.
// Reset (rst, synchronous) and file_start both return the parser to header search.
`timescale 1ns / 1ps
module midi_file_event_parser import mfp_pkg::*; #(
  parameter int TICK_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  file_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  event_kind,
  output logic [3:0]  channel,
  output logic [6:0]  first_data,
  output logic [6:0]  second_data,
  output logic [31:0] tick_time,
  output logic [15:0] track_number,
  output logic [15:0] file_format,
  output logic [15:0] track_count,
  output logic [15:0] ticks_per_quarter,
  output logic [2:0]  error_code
);

  logic    accept, res_valid, full;
  result_t res, q;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  mfp_parse #(.TICK_WIDTH(TICK_WIDTH)) u_parse (
    .clk, .rst, .accept, .file_byte, .file_start, .res_valid, .res
  );

  mfp_outbuf u_outbuf (
    .clk, .rst, .push(accept && res_valid), .din(res), .full,
    .dout_valid(out_valid), .dout_stall(out_stall), .dout(q)
  );

  // Unpack the held transaction
  assign event_kind        = q.kind;
  assign channel           = q.chan;
  assign first_data        = q.d1;
  assign second_data       = q.d2;
  assign tick_time         = q.tick;
  assign track_number      = q.trk;
  assign file_format       = q.fmt;
  assign track_count       = q.ntrk;
  assign ticks_per_quarter = q.div;
  assign error_code        = q.code;

endmodule

### hdl/mfp_checker.sv
// Port-level checks for the MIDI file event parser, bound to the top level.
`timescale 1ns / 1ps
module mfp_checker import mfp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  event_kind,
  input logic [31:0] tick_time,
  input logic [15:0] track_number,
  input logic [2:0]  error_code
);

  // Hold a stalled transaction
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(event_kind) && $stable(tick_time))
    else $error("stalled result changed");

  // Input stalls only behind a waiting result
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // Error code only on error results
  a_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((event_kind == K_ERROR) == (error_code != E_NONE)))
    else $error("error code mismatch");

  // Header carries zero time and track
  a_hdr: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == K_HEADER |-> tick_time == '0 && track_number == '0)
    else $error("header with nonzero time or track");

endmodule

bind midi_file_event_parser mfp_checker u_mfp_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .event_kind, .tick_time,
  .track_number, .error_code
);
